FILE: sv/asc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types, constants and round function for the Ascon-128a decryptor.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam logic [63:0] IV          = 64'h80800c0800000000;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [4:0]  BLOCK_BYTES = 5'd16;
    localparam logic [3:0]  ROUNDS_A    = 4'd12;
    localparam logic [3:0]  ROUNDS_B    = 4'd8;

    // input actions
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_AD    = 2'd1;
    localparam logic [1:0] ACT_CT    = 2'd2;
    localparam logic [1:0] ACT_TAG   = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_PT    = 2'd1;
    localparam logic [1:0] KIND_TAG   = 2'd2;
    localparam logic [1:0] KIND_ERROR = 2'd3;

    // message phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_STARTED = 3'd1;
    localparam logic [2:0] PH_AD      = 3'd2;
    localparam logic [2:0] PH_AD_DONE = 3'd3;
    localparam logic [2:0] PH_CT      = 3'd4;
    localparam logic [2:0] PH_CT_DONE = 3'd5;

    // datapath load operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,       // IV, key, nonce
        OP_KEY_TAIL,   // lanes 3,4 ^= key
        OP_ABSORB,     // xor masked block + pad into rate
        OP_PAD0,       // xor pad at byte 0
        OP_DOMAIN,     // lane4 ^= 1
        OP_CT,         // plaintext out, replace rate with ciphertext (+pad if partial)
        OP_FIN_KEY     // lanes 2,3 ^= key
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       round;     // run one round this cycle
        logic [3:0] rnd_idx;   // round constant index
        logic       capture;   // latch item fields
    } t_cmd;

    typedef struct packed {
        logic       tag_match;
        logic [63:0] text_high;
        logic [63:0] text_low;
    } t_sts;

    function automatic logic [63:0] rot_r(input logic [63:0] v, input int n);
        rot_r = (v >> n) | (v << (64 - n));
    endfunction

    // mask of the first n bytes within the high word
    function automatic logic [63:0] mask_high(input logic [4:0] n);
        if (n >= 5'd8) mask_high = '1;
        else mask_high = ~(64'hffffffffffffffff >> {n[2:0], 3'b000});
    endfunction

    function automatic logic [63:0] mask_low(input logic [4:0] n);
        if (n <= 5'd8) mask_low = '0;
        else if (n >= 5'd16) mask_low = '1;
        else mask_low = ~(64'hffffffffffffffff >> {n[2:0], 3'b000});
    endfunction

    // pad byte at position n (0..15) as a 128-bit word, high lane in the top
    function automatic logic [127:0] pad_at(input logic [4:0] n);
        pad_at = {PAD_BYTE, 120'd0} >> {n[3:0], 3'b000};
    endfunction

    function automatic logic [319:0] round_fn(input logic [319:0] s, input logic [3:0] r);
        logic [63:0] a, b, c, d, e, t0, t1, t2, t3, t4;
        a = s[319:256]; b = s[255:192]; c = s[191:128]; d = s[127:64]; e = s[63:0];
        c = c ^ {56'd0, 4'hf - r, r};
        a = a ^ e; e = e ^ d; c = c ^ b;
        t0 = ~a & b; t1 = ~b & c; t2 = ~c & d; t3 = ~d & e; t4 = ~e & a;
        a = a ^ t1; b = b ^ t2; c = c ^ t3; d = d ^ t4; e = e ^ t0;
        b = b ^ a; a = a ^ e; d = d ^ c; c = ~c;
        round_fn = {a ^ rot_r(a, 19) ^ rot_r(a, 28),
                    b ^ rot_r(b, 61) ^ rot_r(b, 39),
                    c ^ rot_r(c, 1)  ^ rot_r(c, 6),
                    d ^ rot_r(d, 10) ^ rot_r(d, 17),
                    e ^ rot_r(e, 7)  ^ rot_r(e, 41)};
    endfunction

endpackage
`default_nettype wire

FILE: sv/asc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_datapath
// Ascon state register, one permutation round per cycle, block absorb/squeeze.
// ----------------------------------------------------------------------------
module asc_datapath import asc_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic [63:0]  i_key_high,
    input  wire logic [63:0]  i_key_low,
    input  wire logic [63:0]  i_word_high,
    input  wire logic [63:0]  i_word_low,
    input  wire logic [4:0]   i_bytes,     // already clamped to 16
    input  wire t_cmd         i_cmd,
    output t_sts              o_sts
);

    logic [319:0] r_s, n_s;
    logic [63:0]  r_hi, r_lo, r_th, r_tl;
    logic [4:0]   r_n;
    logic [63:0]  mh, ml, s0, s1;
    logic [127:0] pad;

    always_comb begin
        mh  = mask_high(r_n);
        ml  = mask_low(r_n);
        // a full block carries no padding byte
        pad = (r_n >= BLOCK_BYTES) ? 128'd0 : pad_at(r_n);
        s0  = r_s[319:256];
        s1  = r_s[255:192];
        n_s = r_s;
        case (i_cmd.op)
            OP_INIT:     n_s = {IV, i_key_high, i_key_low, r_hi, r_lo};
            OP_KEY_TAIL: n_s = r_s ^ {192'd0, i_key_high, i_key_low};
            OP_ABSORB:   n_s = r_s ^ {(r_hi & mh) ^ pad[127:64],
                                      (r_lo & ml) ^ pad[63:0], 192'd0};
            OP_PAD0:     n_s = r_s ^ {PAD_BYTE, 312'd0};
            OP_DOMAIN:   n_s = r_s ^ 320'd1;
            OP_CT: begin
                if (r_n == BLOCK_BYTES) begin
                    n_s[319:192] = {r_hi, r_lo};
                end else begin
                    n_s[319:192] = {(s0 & ~mh) | (r_hi & mh), (s1 & ~ml) | (r_lo & ml)}
                                   ^ pad;
                end
            end
            OP_FIN_KEY:  n_s = r_s ^ {128'd0, i_key_high, i_key_low, 64'd0};
            default:     n_s = r_s;
        endcase
        if (i_cmd.round) n_s = round_fn(r_s, i_cmd.rnd_idx);
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        if (i_cmd.capture) begin
            r_hi <= i_word_high;
            r_lo <= i_word_low;
            r_n  <= i_bytes;
        end
        if (i_cmd.op == OP_CT) begin
            r_th <= (s0 ^ r_hi) & mh;
            r_tl <= (s1 ^ r_lo) & ml;
        end
    end

    assign o_sts.text_high = r_th;
    assign o_sts.text_low  = r_tl;
    assign o_sts.tag_match = ((r_s[127:64] ^ r_hi) | (r_s[63:0] ^ r_lo)) == 64'd0;

endmodule
`default_nettype wire

FILE: sv/asc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asc_ctrl
// Sequencer: decodes the item against the message phase, steps the datapath
// through loads and permutation rounds, builds the result.
// ----------------------------------------------------------------------------
module asc_ctrl import asc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_fire,
    input  wire logic [1:0]  i_action,
    input  wire logic [4:0]  i_bytes,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [4:0]       o_text_bytes,
    output logic             o_pt_sel,     // text fields come from datapath
    output logic             o_tag_sel,    // tag flag comes from datapath
    output logic [2:0]       o_phase,
    output t_cmd             o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RND, S_KEY_TAIL, S_AD, S_PAD_AD, S_DOMAIN,
        S_CT, S_TAG_PAD, S_FIN_KEY, S_DONE, S_OUT
    } t_state;

    t_state     r_state, r_after;
    logic [3:0] r_rnd;
    logic [2:0] r_phase;
    logic [1:0] r_kind;
    logic [4:0] r_n, r_tb;
    logic       r_valid, r_pt, r_tg, r_ct_after;

    assign o_in_ready   = (r_state == S_IDLE) && !r_valid;
    assign o_out_valid  = r_valid;
    assign o_kind       = r_kind;
    assign o_text_bytes = r_tb;
    assign o_pt_sel     = r_pt;
    assign o_tag_sel    = r_tg;
    assign o_phase      = r_phase;

    always_comb begin
        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.capture = i_in_fire;
        o_cmd.rnd_idx = r_rnd;
        case (r_state)
            S_INIT:     o_cmd.op = OP_INIT;
            S_RND:      o_cmd.round = 1'b1;
            S_KEY_TAIL: o_cmd.op = OP_KEY_TAIL;
            S_AD:       o_cmd.op = OP_ABSORB;
            S_PAD_AD:   o_cmd.op = OP_PAD0;
            S_DOMAIN:   o_cmd.op = OP_DOMAIN;
            S_CT:       o_cmd.op = OP_CT;
            S_TAG_PAD:  o_cmd.op = OP_PAD0;
            S_FIN_KEY:  o_cmd.op = OP_FIN_KEY;
            S_DONE:     o_cmd.op = OP_KEY_TAIL;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_after <= S_IDLE;
            r_phase <= PH_IDLE;
            r_valid <= 1'b0;
            r_rnd   <= '0;
            r_n     <= '0;
            r_kind  <= KIND_ACK;
            r_tb    <= '0;
            r_pt    <= 1'b0;
            r_tg    <= 1'b0;
            r_ct_after <= 1'b0;
        end else begin
            if (r_valid && i_out_ready) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_fire) begin
                        r_n   <= i_bytes;
                        r_kind <= KIND_ACK; r_tb <= '0; r_pt <= 1'b0; r_tg <= 1'b0;
                        case (i_action)
                            ACT_START: r_state <= S_INIT;
                            ACT_AD: begin
                                if (r_phase != PH_STARTED && r_phase != PH_AD) begin
                                    r_kind <= KIND_ERROR; r_state <= S_OUT;
                                end else if (i_bytes == BLOCK_BYTES) begin
                                    r_phase <= PH_AD; r_state <= S_AD;
                                end else if (i_bytes == 5'd0 && r_phase == PH_STARTED) begin
                                    r_phase <= PH_AD_DONE; r_state <= S_OUT;
                                end else begin
                                    r_phase <= PH_AD_DONE; r_state <= S_AD;
                                end
                            end
                            ACT_CT: begin
                                if (r_phase < PH_STARTED || r_phase > PH_CT) begin
                                    r_kind <= KIND_ERROR; r_state <= S_OUT;
                                end else if (r_phase == PH_AD) begin
                                    r_ct_after <= 1'b1; r_state <= S_PAD_AD;
                                end else if (r_phase != PH_CT) begin
                                    r_ct_after <= 1'b1; r_state <= S_DOMAIN;
                                end else begin
                                    r_state <= S_CT;
                                end
                            end
                            default: begin
                                if (r_phase < PH_STARTED || r_phase > PH_CT_DONE) begin
                                    r_kind <= KIND_ERROR; r_state <= S_OUT;
                                end else if (r_phase == PH_AD) begin
                                    r_ct_after <= 1'b0; r_state <= S_PAD_AD;
                                end else if (r_phase < PH_CT) begin
                                    r_ct_after <= 1'b0; r_state <= S_DOMAIN;
                                end else if (r_phase == PH_CT) begin
                                    r_state <= S_TAG_PAD;
                                end else begin
                                    r_state <= S_FIN_KEY;
                                end
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    r_rnd <= 4'd0;
                    r_after <= S_KEY_TAIL; r_state <= S_RND;
                end
                S_RND: begin
                    r_rnd <= r_rnd + 4'd1;
                    if (r_rnd == ROUNDS_A - 4'd1) r_state <= r_after;
                end
                S_KEY_TAIL: begin
                    r_phase <= PH_STARTED; r_state <= S_OUT;
                end
                S_AD: begin
                    r_rnd <= ROUNDS_A - ROUNDS_B; r_after <= S_OUT; r_state <= S_RND;
                end
                S_PAD_AD: begin
                    r_rnd <= ROUNDS_A - ROUNDS_B; r_after <= S_DOMAIN; r_state <= S_RND;
                end
                S_DOMAIN: begin
                    r_phase <= PH_CT;
                    if (r_ct_after) r_state <= S_CT;
                    else r_state <= S_TAG_PAD;
                end
                S_CT: begin
                    r_kind <= KIND_PT; r_pt <= 1'b1; r_tb <= r_n;
                    if (r_n == BLOCK_BYTES) begin
                        r_rnd <= ROUNDS_A - ROUNDS_B; r_after <= S_OUT; r_state <= S_RND;
                    end else begin
                        r_phase <= PH_CT_DONE; r_state <= S_OUT;
                    end
                end
                S_TAG_PAD: r_state <= S_FIN_KEY;
                S_FIN_KEY: begin
                    r_rnd <= 4'd0; r_after <= S_DONE; r_state <= S_RND;
                end
                S_DONE: begin
                    r_kind <= KIND_TAG; r_tg <= 1'b1; r_phase <= PH_IDLE;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_valid <= 1'b1; r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/ascon128a_aead_decrypt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ascon128a_aead_decrypt
// Ascon-128a authenticated decryption, one 16-byte block per transfer.
// ----------------------------------------------------------------------------
// Usage: write the key through i_cfg_we/i_cfg_index/i_cfg_data while idle
// (index 0 key_high, 1 key_low). Send a start transfer with the nonce, then
// associated-data blocks, ciphertext blocks and the tag on s_axis. Every
// transfer gives exactly one result on m_axis: ack, plaintext, tag verdict
// or order error.
// Timing: one permutation round per cycle in a single shared round unit.
// Steps from the input transfer to m_axis_tvalid: start loads IV, key and
// nonce, permutes and xors in the key; associated data is absorbed and
// permuted, but not an empty first block; ciphertext pads open associated
// data, permutes, sets the domain bit once, xors out plaintext, permutes if
// full; the tag closes likewise, pads if unpadded, xors the key, permutes.
// One item is in flight at a time; s_axis_tready returns in the cycle after
// the result transfer.
// Reset (synchronous, active low) returns to idle with no message open.
// If m_axis_tready is low the result holds in its register and the next
// input transfer waits until it is taken.
// ----------------------------------------------------------------------------
module ascon128a_aead_decrypt import asc_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] word_high, [127:64] word_low, [132:128] byte_count, [135:133] zero
    input  wire logic [135:0] s_axis_tdata,
    // [1:0] action
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [63:0] text_high, [127:64] text_low, [132:128] text_bytes,
    // [133] tag_match, [135:134] zero
    output logic [135:0]      m_axis_tdata,
    // [1:0] kind
    output logic [1:0]        m_axis_tuser
);

    logic [63:0] r_key_high, r_key_low;
    logic [4:0]  bytes;
    logic        in_fire, pt_sel, tag_sel;
    logic [1:0]  kind;
    logic [4:0]  tb;
    logic [2:0]  phase;
    t_cmd        cmd;
    t_sts        sts;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == 1'b0) r_key_high <= i_cfg_data;
            else r_key_low <= i_cfg_data;
        end
    end

    assign bytes   = (s_axis_tdata[132:128] > BLOCK_BYTES) ? BLOCK_BYTES
                                                           : s_axis_tdata[132:128];
    assign in_fire = s_axis_tvalid && s_axis_tready;

    asc_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_fire    (in_fire),
        .i_action     (s_axis_tuser),
        .i_bytes      (bytes),
        .o_in_ready   (s_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_kind       (kind),
        .o_text_bytes (tb),
        .o_pt_sel     (pt_sel),
        .o_tag_sel    (tag_sel),
        .o_phase      (phase),
        .o_cmd        (cmd)
    );

    asc_datapath u_dp (
        .i_clk,
        .i_key_high  (r_key_high),
        .i_key_low   (r_key_low),
        .i_word_high (s_axis_tdata[63:0]),
        .i_word_low  (s_axis_tdata[127:64]),
        .i_bytes     (bytes),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    assign m_axis_tuser = kind;
    assign m_axis_tdata = {2'b00, tag_sel & sts.tag_match, tb,
                           pt_sel ? sts.text_low  : 64'd0,
                           pt_sel ? sts.text_high : 64'd0};

    // no new transfer while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input accepted with result pending");

    // a tag verdict closes the message
    a_tag_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_TAG) |-> phase == PH_IDLE)
        else $error("phase not idle after tag");

    // an accepted transfer yields no result in the cycle after the accept
    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !m_axis_tvalid)
        else $error("result too early");

endmodule
`default_nettype wire
